/* design/video_byte_pixel_expander_top_assert.svh */
// Assertion macros shared by the expander's modules.
`ifndef VIDEO_BYTE_PIXEL_EXPANDER_TOP_ASSERT_SVH
`define VIDEO_BYTE_PIXEL_EXPANDER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define VBPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VBPE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VBPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define VBPE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* design/vbpe_pkg.sv */
`default_nettype none

package vbpe_pkg;

    // Video mode codes.
    localparam logic [2:0] MODE_LORES  = 3'd0;
    localparam logic [2:0] MODE_MEDRES = 3'd1;
    localparam logic [2:0] MODE_HIRES  = 3'd2;
    localparam logic [2:0] MODE_QUAD   = 3'd3;
    localparam logic [2:0] MODE_DOUBLE = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_PAGE = 2'd1;
    localparam logic [1:0] REG_CMAP = 2'd2;

    localparam logic [3:0] COLOR_WHITE = 4'd15;
    localparam logic [3:0] COLOR_BLACK = 4'd0;

    // How the back end splits a byte into spans.
    typedef enum logic [1:0] {
        KIND_NIBBLE,
        KIND_MONO,
        KIND_QUAD
    } t_kind;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  page;
        logic [15:0] cmap;
    } t_cfg;

    typedef struct packed {
        logic [16:0] addr;
        logic [8:0]  x0;
        t_kind       kind;
        logic [1:0]  wsh;
        logic [7:0]  pix;
        logic [15:0] cmap;
    } t_desc;

    typedef struct packed {
        logic [16:0] addr;
        logic [8:0]  x;
        logic [3:0]  run;
        logic [3:0]  color;
        logic        last;
    } t_span;

endpackage

`default_nettype wire

/* design/vbpe_front.sv */
`default_nettype none

module vbpe_front
    import vbpe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_line,
    input  wire  [5:0]  i_col,
    input  wire  [7:0]  i_pix,
    output logic        o_desc_valid,
    output t_desc       o_desc,
    input  wire         i_desc_ready
);

    logic  r_valid;
    t_desc r_desc;
    logic  n_keep;
    t_desc n_desc;

    // Address, span layout and column check for the current mode.
    always_comb begin
        n_keep      = 1'b0;
        n_desc      = '0;
        n_desc.pix  = i_pix;
        n_desc.cmap = i_cfg.cmap;
        case (i_cfg.mode)
            MODE_LORES: begin
                n_keep      = !i_col[5];
                n_desc.kind = KIND_NIBBLE;
                n_desc.wsh  = 2'd3;
                n_desc.x0   = {i_col[4:0], 4'b0};
                n_desc.addr = (17'(i_cfg.page) << 11) + 17'({i_line[7:2], 5'b0})
                            + 17'(i_col);
            end
            MODE_MEDRES: begin
                n_keep      = 1'b1;
                n_desc.kind = KIND_NIBBLE;
                n_desc.wsh  = 2'd2;
                n_desc.x0   = {i_col, 3'b0};
                n_desc.addr = (17'(i_cfg.page) << 13) + 17'({i_line[7:1], 6'b0})
                            + 17'(i_col);
            end
            MODE_HIRES: begin
                n_keep      = !i_col[5];
                n_desc.kind = KIND_MONO;
                n_desc.wsh  = 2'd1;
                n_desc.x0   = {i_col[4:0], 4'b0};
                n_desc.addr = (17'(i_cfg.page) << 13) + 17'({i_line, 5'b0})
                            + 17'(i_col);
            end
            MODE_QUAD, MODE_DOUBLE: begin
                n_keep      = 1'b1;
                n_desc.kind = (i_cfg.mode == MODE_QUAD) ? KIND_QUAD : KIND_MONO;
                n_desc.wsh  = (i_cfg.mode == MODE_QUAD) ? 2'd1 : 2'd0;
                n_desc.x0   = {i_col, 3'b0};
                n_desc.addr = (17'(i_cfg.page) << 14) + (17'(i_line[0]) << 13)
                            + 17'({i_line[7:1], 6'b0}) + 17'(i_col);
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign o_ready      = !r_valid || i_desc_ready;
    assign o_desc_valid = r_valid;
    assign o_desc       = r_desc;

    // Bytes that paint nothing are taken and dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_desc <= n_desc;
        end
    end

endmodule

`default_nettype wire

/* design/vbpe_fifo.sv */
`default_nettype none
`include "video_byte_pixel_expander_top_assert.svh"

module vbpe_fifo
    import vbpe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_desc  i_push_data,
    output logic   o_full,
    input  wire    i_pop,
    output logic   o_nonempty,
    output t_desc  o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_pop_data = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    `VBPE_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH), "queue count overflow")
    `VBPE_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) |-> (r_wr == r_rd), "empty queue with pointers apart")

endmodule

`default_nettype wire

/* design/vbpe_back.sv */
`default_nettype none
`include "video_byte_pixel_expander_top_assert.svh"

module vbpe_back
    import vbpe_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_desc_valid,
    input  t_desc  i_desc,
    output logic   o_pop,
    output logic   o_valid,
    input  wire    i_ready,
    output t_span  o_span
);

    logic       r_busy;
    t_desc      r_desc;
    logic [2:0] r_idx;
    logic       r_out_valid;
    t_span      r_out;

    logic       advance;
    logic       span_last;
    logic [7:0] mono_bits;
    logic [7:0] quad_bits;
    logic [1:0] sel;
    t_span      n_span;

    always_comb begin
        mono_bits = r_desc.pix << r_idx;
        quad_bits = r_desc.pix << {r_idx[1:0], 1'b0};
        sel       = quad_bits[7:6];
        n_span.addr = r_desc.addr;
        n_span.x    = r_desc.x0 + (9'(r_idx) << r_desc.wsh);
        n_span.run  = 4'd1 << r_desc.wsh;
        case (r_desc.kind)
            KIND_NIBBLE: begin
                span_last    = (r_idx == 3'd1);
                n_span.color = r_idx[0] ? r_desc.pix[3:0] : r_desc.pix[7:4];
            end
            KIND_QUAD: begin
                span_last    = (r_idx == 3'd3);
                n_span.color = r_desc.cmap[{sel, 2'b0} +: 4];
            end
            KIND_MONO: begin
                span_last    = (r_idx == 3'd7);
                n_span.color = mono_bits[7] ? COLOR_WHITE : COLOR_BLACK;
            end
            default: begin
                span_last    = 1'b1;
                n_span.color = COLOR_BLACK;
            end
        endcase
        n_span.last = span_last;
    end

    // One span leaves per cycle while i_ready is high; the next byte is
    // fetched while its predecessor's final span loads, with no gap.
    assign advance = !r_out_valid || i_ready;
    assign o_pop   = advance && (!r_busy || span_last) && i_desc_valid;
    assign o_valid = r_out_valid;
    assign o_span  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (span_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_busy) begin
                r_out <= n_span;
            end
            if (o_pop) begin
                r_desc <= i_desc;
                r_idx  <= '0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    `VBPE_ASSERT(a_nibble_idx, i_clk, i_rst_n, (r_busy && r_desc.kind == KIND_NIBBLE) |-> (r_idx <= 3'd1), "nibble span index out of range")
    `VBPE_ASSERT(a_quad_idx, i_clk, i_rst_n, (r_busy && r_desc.kind == KIND_QUAD) |-> (r_idx <= 3'd3), "four-color span index out of range")
    `VBPE_ASSERT(a_mid_byte, i_clk, i_rst_n, (r_out_valid && i_ready && !r_out.last) |-> r_busy, "byte left before its last span")

endmodule

`default_nettype wire

/* design/video_byte_pixel_expander_top.sv */
// Video byte pixel expander.
// The input stream carries one video memory byte per word with its scanline and
// byte column. For each byte the output stream carries a run of pixel spans,
// left to right, each with the byte's fetch address, start x, width and palette
// index; tlast marks the final span of the byte. Low-res and medium-res give two
// spans, four-color gives four, hi-res and double-res mono give eight. A byte
// whose column lies past the mode's line, or any byte in an undefined mode, is
// taken and gives no spans.
// An accepted byte passes the decoder register, the queue, the generator's byte
// register and the output register before its first span leaves. The span
// generator emits one span per cycle while the receiver is ready and so sets
// the sustained rate. A queue of FIFO_DEPTH decoded bytes sits between the
// decoder and generator; input is taken every cycle while the queue has room.
// When the receiver stalls the current span holds in the output register and the
// queue fills; once it is full, tready falls. Reset clears the configuration
// registers to zero, empties the queue and drops any span in flight.
// The user must write configuration through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle, which it does not enforce; index 3 is ignored.
`default_nettype none

module video_byte_pixel_expander_top
    import vbpe_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // scanline [7:0], column [13:8], pixel_byte [21:14], zero [23:22]
    input  wire  [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // fetch_addr [16:0], pixel_x [25:17], run_length [29:26],
    // color_index [33:30], zero [39:34]
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    t_cfg  r_cfg;
    logic  front_valid;
    t_desc front_desc;
    logic  fifo_full;
    logic  fifo_nonempty;
    t_desc fifo_desc;
    logic  back_pop;
    t_span span;

    // Configuration registers; writes are masked to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE: r_cfg.mode <= i_cfg_data[2:0];
                REG_PAGE: r_cfg.page <= i_cfg_data[2:0];
                REG_CMAP: r_cfg.cmap <= i_cfg_data;
                default:  r_cfg      <= r_cfg;
            endcase
        end
    end

    // Decoder: works out the address and span layout of each byte.
    vbpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_line       (i_s_axis_tdata[7:0]),
        .i_col        (i_s_axis_tdata[13:8]),
        .i_pix        (i_s_axis_tdata[21:14]),
        .o_desc_valid (front_valid),
        .o_desc       (front_desc),
        .i_desc_ready (!fifo_full)
    );

    vbpe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .i_push_data (front_desc),
        .o_full      (fifo_full),
        .i_pop       (back_pop),
        .o_nonempty  (fifo_nonempty),
        .o_pop_data  (fifo_desc)
    );

    // Span generator: registered output; one span per cycle unless stalled.
    vbpe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (fifo_nonempty),
        .i_desc       (fifo_desc),
        .o_pop        (back_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_span       (span)
    );

    assign o_m_axis_tdata = {6'b0, span.color, span.run, span.x, span.addr};
    assign o_m_axis_tlast = span.last;

endmodule

`default_nettype wire
